/* design/wbps_pkg.sv */
package wbps_pkg;

    // Window depth and offset counter width.
    localparam int MAX_PATTERN_BYTES = 16;
    localparam int OFFSET_WIDTH      = 32;

    // Width that holds a length of 0 .. MAX_PATTERN_BYTES, and an index into the window.
    localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    // Fixed field widths.
    localparam int BYTE_W         = 8;
    localparam int MATCH_OFFSET_W = 32;
    localparam int PATTERN_LEN_W  = 5;
    localparam int WILDCARD_W     = 16;
    localparam int CFG_INDEX_W    = 8;
    localparam int CFG_DATA_W     = 64;

    // Width used to widen or cut the internal offset to the reported one.
    localparam int EXT_W = (OFFSET_WIDTH > MATCH_OFFSET_W) ? OFFSET_WIDTH : MATCH_OFFSET_W;

    localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = {OFFSET_WIDTH{1'b1}};

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LOW    = 8'd0,
        CFG_PATTERN_HIGH   = 8'd1,
        CFG_WILDCARD_MASK  = 8'd2,
        CFG_PATTERN_LENGTH = 8'd3
    } cfg_reg_t;

    typedef logic [BYTE_W-1:0]       byte_t;
    typedef logic [OFFSET_WIDTH-1:0] offset_t;

    // What a window cell compares against.
    typedef struct packed {
        logic  care;
        byte_t expected;
    } cell_cfg_t;

endpackage

/* design/wbps_cell.sv */
module wbps_cell
(
    input  logic               clk,
    input  logic               shift_en,
    input  wbps_pkg::byte_t    in_byte,
    input  wbps_pkg::offset_t  in_offset,
    input  wbps_pkg::cell_cfg_t cell_cfg,
    output wbps_pkg::byte_t    byte_out,
    output wbps_pkg::offset_t  offset_out,
    output logic               match
);

    wbps_pkg::byte_t   byte_reg;
    wbps_pkg::offset_t offset_reg;

    // The cell judges the byte it is about to take in, so the row compares
    // the window as it will stand after this shift.
    assign match = !cell_cfg.care || (in_byte == cell_cfg.expected);

    assign byte_out   = byte_reg;
    assign offset_out = offset_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            byte_reg   <= in_byte;
            offset_reg <= in_offset;
        end
    end

endmodule

/* design/wildcard_byte_pattern_scan.sv */
// Wildcard byte pattern scanner. Region bytes arrive on the slave stream one
// per transfer, and every accepted transfer yields exactly one result transfer
// on the master stream. The pattern (up to 16 bytes, each optionally a
// wildcard) is tried at every alignment of the readable bytes; the first match
// in a region reports the offset of its first byte, later matches in the same
// region are suppressed, and the last byte of a region flags a miss when
// nothing matched. Unreadable bytes are skipped but still advance the
// saturating offset counter. Throughput is one byte per clock while results are
// taken: the window is a row of cells that shift once per readable byte, and all
// cells compare in the same cycle. Each result is held in the single output
// register from the cycle after its byte is accepted. A new byte is accepted
// when that register is empty or in the same cycle as its result is taken, so a
// stalled result holds the input off until it goes. Configuration writes are
// always accepted and should only be made while no result is outstanding.
module wildcard_byte_pattern_scan
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write channel.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wbps_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Byte stream in.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,  // [7:0] data_byte
    input  logic [1:0]                           s_tuser,  // [0] byte_readable, [1] region_start
    input  logic                                 s_tlast,  // last_in_region
    // Result stream out.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [31:0]                          m_tdata,  // [31:0] match_offset
    output logic [1:0]                           m_tuser   // [0] found, [1] region_missed
);

    localparam int N = wbps_pkg::MAX_PATTERN_BYTES;

    // Configuration registers.
    logic [63:0]                            pattern_low_reg;
    logic [63:0]                            pattern_high_reg;
    logic [wbps_pkg::WILDCARD_W-1:0]        wildcard_mask_reg;
    logic [wbps_pkg::PATTERN_LEN_W-1:0]     pattern_length_reg;

    // Scan state.
    logic [wbps_pkg::LEN_W-1:0]             fill_count_reg;
    logic [wbps_pkg::LEN_W-1:0]             fill_count_next;
    wbps_pkg::offset_t                      byte_position_reg;
    wbps_pkg::offset_t                      byte_position_next;
    logic                                   match_done_reg;
    logic                                   match_done_next;

    // Output register.
    logic                                   m_tvalid_reg;
    logic                                   found_reg;
    logic                                   found_next;
    logic                                   region_missed_reg;
    logic                                   region_missed_next;
    logic [wbps_pkg::MATCH_OFFSET_W-1:0]    match_offset_reg;
    logic [wbps_pkg::MATCH_OFFSET_W-1:0]    match_offset_next;

    logic                                   accept;
    logic                                   shift_en;
    logic                                   readable;
    logic                                   start;
    logic [wbps_pkg::LEN_W-1:0]             used_len;
    logic [wbps_pkg::LEN_W-1:0]             fill_cur;
    logic [wbps_pkg::LEN_W-1:0]             fill_new;
    wbps_pkg::offset_t                      pos_cur;
    logic                                   done_cur;
    logic                                   hit;
    logic [wbps_pkg::IDX_W-1:0]             head_idx;
    wbps_pkg::offset_t                      head_offset;
    logic [wbps_pkg::EXT_W-1:0]             head_offset_ext;

    wbps_pkg::byte_t                        pattern_bytes [N];
    wbps_pkg::byte_t                        cell_in_byte  [N];
    wbps_pkg::offset_t                      cell_in_off   [N];
    wbps_pkg::byte_t                        cell_byte     [N];
    wbps_pkg::offset_t                      cell_off      [N];
    wbps_pkg::cell_cfg_t                    cell_cfg      [N];
    logic [N-1:0]                           cell_match;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign readable  = s_tuser[0];
    assign start     = s_tuser[1];
    assign shift_en  = accept && readable;

    // Length in use: zero counts as one, anything past the window as the window.
    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            used_len = wbps_pkg::LEN_W'(1);
        end
        else if (pattern_length_reg > wbps_pkg::PATTERN_LEN_W'(N))
        begin
            used_len = wbps_pkg::LEN_W'(N);
        end
        else
        begin
            used_len = wbps_pkg::LEN_W'(pattern_length_reg);
        end
    end

    // Cell j holds the j-th newest readable byte. With a pattern of length L,
    // the oldest byte in use (cell L-1) lines up with pattern byte 0, so cell j
    // checks pattern byte L-1-j and cells at or past L take no part.
    genvar j;
    generate
        for (j = 0; j < N; j++)
        begin : g_row
            logic [wbps_pkg::IDX_W-1:0] pat_idx;

            if (j < 8)
            begin : g_low
                assign pattern_bytes[j] = pattern_low_reg[8*j +: 8];
            end
            else
            begin : g_high
                assign pattern_bytes[j] = pattern_high_reg[8*(j-8) +: 8];
            end

            if (j == 0)
            begin : g_head
                assign cell_in_byte[j] = s_tdata;
                assign cell_in_off[j]  = pos_cur;
            end
            else
            begin : g_link
                assign cell_in_byte[j] = cell_byte[j-1];
                assign cell_in_off[j]  = cell_off[j-1];
            end

            assign pat_idx = wbps_pkg::IDX_W'(used_len - wbps_pkg::LEN_W'(1)
                                              - wbps_pkg::LEN_W'(j));
            assign cell_cfg[j].care = (used_len > wbps_pkg::LEN_W'(j))
                                      && !wildcard_mask_reg[pat_idx];
            assign cell_cfg[j].expected = pattern_bytes[pat_idx];

            wbps_cell u_cell
            (
                .clk        (clk),
                .shift_en   (shift_en),
                .in_byte    (cell_in_byte[j]),
                .in_offset  (cell_in_off[j]),
                .cell_cfg   (cell_cfg[j]),
                .byte_out   (cell_byte[j]),
                .offset_out (cell_off[j]),
                .match      (cell_match[j])
            );
        end
    endgenerate

    // The offset of a match is that of the byte entering the oldest cell in use.
    assign head_idx        = wbps_pkg::IDX_W'(used_len - wbps_pkg::LEN_W'(1));
    assign head_offset     = cell_in_off[head_idx];
    assign head_offset_ext = wbps_pkg::EXT_W'(head_offset);

    // A region start clears the window count, offset and done flag before
    // this byte is processed.
    always_comb
    begin
        fill_cur = start ? '0 : fill_count_reg;
        pos_cur  = start ? '0 : byte_position_reg;
        done_cur = start ? 1'b0 : match_done_reg;

        if (pos_cur != wbps_pkg::OFFSET_MAX)
        begin
            byte_position_next = pos_cur + wbps_pkg::OFFSET_WIDTH'(1);
        end
        else
        begin
            byte_position_next = pos_cur;
        end

        if (fill_cur != wbps_pkg::LEN_W'(N))
        begin
            fill_new = fill_cur + wbps_pkg::LEN_W'(1);
        end
        else
        begin
            fill_new = fill_cur;
        end

        hit = readable && (fill_new >= used_len) && (&cell_match) && !done_cur;

        fill_count_next    = readable ? fill_new : fill_cur;
        match_done_next    = done_cur || hit;
        found_next         = hit;
        match_offset_next  = hit ? head_offset_ext[wbps_pkg::MATCH_OFFSET_W-1:0] : '0;
        region_missed_next = s_tlast && !match_done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            wildcard_mask_reg  <= '0;
            pattern_length_reg <= wbps_pkg::PATTERN_LEN_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                wbps_pkg::CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                wbps_pkg::CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                wbps_pkg::CFG_WILDCARD_MASK:
                    wildcard_mask_reg  <= cfg_data[wbps_pkg::WILDCARD_W-1:0];
                wbps_pkg::CFG_PATTERN_LENGTH:
                    pattern_length_reg <= cfg_data[wbps_pkg::PATTERN_LEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg    <= '0;
            byte_position_reg <= '0;
            match_done_reg    <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end
        else if (accept)
        begin
            fill_count_reg    <= fill_count_next;
            byte_position_reg <= byte_position_next;
            match_done_reg    <= match_done_next;
            m_tvalid_reg      <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg      <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            found_reg         <= found_next;
            match_offset_reg  <= match_offset_next;
            region_missed_reg <= region_missed_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = match_offset_reg;
    assign m_tuser  = {region_missed_reg, found_reg};

endmodule

/* design/wbps_checker.sv */
module wbps_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A region that just matched cannot also be reported as missed.
    a_found_not_missed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("found and region_missed both set");

    // The offset is only meaningful with found, and reads as zero otherwise.
    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 32'd0))
        else $error("nonzero match_offset without found");

    // With the output register empty the block must take a new byte.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while no result is pending");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule

bind wildcard_byte_pattern_scan wbps_checker u_wbps_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* bench/wildcard_byte_pattern_scan_test.sv */
module wildcard_byte_pattern_scan_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Register index that the block does not decode. Writes to it must change nothing.
    localparam logic [wbps_pkg::CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 8'hFF;

    // Least number of random transfers sent per configuration phase, and the number of phases.
    localparam int PHASE_BYTES = 32;
    localparam int PHASE_COUNT = 9;

    // One result transfer, split into its fields.
    typedef struct packed {
        logic                                found;
        logic [wbps_pkg::MATCH_OFFSET_W-1:0] match_offset;
        logic                                region_missed;
    } scan_result_t;

    // One byte of a region as the stimulus builds it up.
    typedef struct packed {
        wbps_pkg::byte_t data;
        logic            readable;
    } region_byte_t;

    // Kinds of rows in the directed table. A register write waits for the block to
    // go idle. A plain byte is checked against the predictor. A known byte carries
    // its expected result in the row itself.
    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_BYTE,
        ROW_KNOWN
    } row_kind_t;

    typedef struct {
        row_kind_t                           kind;
        logic [wbps_pkg::CFG_INDEX_W-1:0]    reg_index;
        logic [wbps_pkg::CFG_DATA_W-1:0]     reg_value;
        wbps_pkg::byte_t                     data;
        logic                                readable;
        logic                                start;
        logic                                last;
        logic                                found;
        logic [wbps_pkg::MATCH_OFFSET_W-1:0] match_offset;
        logic                                region_missed;
    } row_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [wbps_pkg::CFG_INDEX_W-1:0]   cfg_index = '0;
    logic [wbps_pkg::CFG_DATA_W-1:0]    cfg_data = '0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [7:0]                         s_tdata = '0;
    logic [1:0]                         s_tuser = '0;
    logic                               s_tlast = 1'b0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b1;
    logic [31:0]                        m_tdata;
    logic [1:0]                         m_tuser;

    wildcard_byte_pattern_scan dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow copy of the configuration registers, at their reset values.
    logic [63:0] pattern_lo   = '0;
    logic [63:0] pattern_hi   = '0;
    logic [15:0] wild_mask    = '0;
    logic [4:0]  pattern_len  = 5'd1;

    // Shadow copy of the scanner state. Entry 0 of the history is the newest
    // readable byte, together with the region offset it arrived at.
    wbps_pkg::byte_t   hist_byte [wbps_pkg::MAX_PATTERN_BYTES];
    wbps_pkg::offset_t hist_off  [wbps_pkg::MAX_PATTERN_BYTES];
    int                hist_fill   = 0;
    wbps_pkg::offset_t next_offset = '0;
    logic              region_hit  = 1'b0;

    // Results still owed by the block, oldest first.
    scan_result_t pending_results [$];
    int           mismatch_count = 0;

    // Set while the sender leaves tvalid high for the next byte.
    bit           valid_held = 1'b0;
    int           burst_left = 0;

    region_byte_t region_bytes [$];
    row_t         directed_rows [0:27];

    // A length of zero counts as one, and anything past the window depth as the
    // full depth.
    function automatic int used_length(logic [4:0] len);
        if (len == 0)
            return 1;
        if (len > wbps_pkg::MAX_PATTERN_BYTES)
            return wbps_pkg::MAX_PATTERN_BYTES;
        return int'(len);
    endfunction

    // Advances the shadow state by one byte and returns the result that byte owes.
    function automatic scan_result_t predict_scan(wbps_pkg::byte_t data, logic readable,
                                                  logic start, logic last);
        scan_result_t      r;
        wbps_pkg::offset_t here;
        logic [127:0]      pat;
        int                len;
        logic              hit;

        r   = '0;
        pat = {pattern_hi, pattern_lo};
        len = used_length(pattern_len);

        if (start)
        begin
            hist_fill   = 0;
            next_offset = '0;
            region_hit  = 1'b0;
        end

        // The offset counter sticks at its top value.
        here = next_offset;
        if (next_offset != wbps_pkg::OFFSET_MAX)
            next_offset = next_offset + 1'b1;

        // Unreadable bytes only take up an offset; they never enter the window,
        // so no match can end on one.
        if (readable)
        begin
            for (int i = wbps_pkg::MAX_PATTERN_BYTES - 1; i > 0; i--)
            begin
                hist_byte[i] = hist_byte[i-1];
                hist_off[i]  = hist_off[i-1];
            end
            hist_byte[0] = data;
            hist_off[0]  = here;
            if (hist_fill < wbps_pkg::MAX_PATTERN_BYTES)
                hist_fill++;

            // Pattern byte 0 lines up with the oldest byte of the window slice.
            hit = (hist_fill >= len);
            for (int i = 0; i < len; i++)
                if (!wild_mask[i] && hist_byte[len-1-i] != pat[8*i +: 8])
                    hit = 1'b0;

            if (hit && !region_hit)
            begin
                r.found        = 1'b1;
                r.match_offset = hist_off[len-1];
                region_hit     = 1'b1;
            end
        end

        r.region_missed = last && !region_hit;
        return r;
    endfunction

    // Sends one byte and records what it must produce. The sender works in bursts:
    // inside a burst tvalid stays high, and between most bursts it drops.
    task automatic push_byte(wbps_pkg::byte_t data, logic readable, logic start, logic last,
                             bit use_given, scan_result_t given);
        scan_result_t want;
        int           gap;

        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= {start, readable};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);

        want = predict_scan(data, readable, start, last);
        if (use_given)
            want = given;
        pending_results.push_back(want);

        if (burst_left > 0)
        begin
            burst_left--;
            valid_held = 1'b1;
        end
        else
        begin
            // A quarter of the bursts run on straight into the next one.
            burst_left = $urandom_range(0, 30);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
            if (gap == 0)
            begin
                valid_held = 1'b1;
            end
            else
            begin
                s_tvalid  <= 1'b0;
                valid_held = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stops the byte stream and waits until every owed result has come back.
    // Every byte owes exactly one result, so an empty queue means the block is idle.
    task automatic drain_stream();
        if (valid_held)
        begin
            s_tvalid  <= 1'b0;
            valid_held = 1'b0;
            @(posedge clk);
        end
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // One register write. The shadow copy takes the same bits the block keeps.
    task automatic write_reg(logic [wbps_pkg::CFG_INDEX_W-1:0] index,
                             logic [wbps_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;

        case (index)
            wbps_pkg::CFG_PATTERN_LOW:    pattern_lo  = value;
            wbps_pkg::CFG_PATTERN_HIGH:   pattern_hi  = value;
            wbps_pkg::CFG_WILDCARD_MASK:  wild_mask   = value[wbps_pkg::WILDCARD_W-1:0];
            wbps_pkg::CFG_PATTERN_LENGTH: pattern_len = value[wbps_pkg::PATTERN_LEN_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Filler byte: mostly readable, sometimes skipped.
    function automatic region_byte_t filler_byte();
        region_byte_t b;
        b.data     = wbps_pkg::byte_t'($urandom);
        b.readable = ($urandom_range(0, 9) != 0);
        return b;
    endfunction

    // Appends the first n pattern bytes to the region, with random content where
    // the byte is a wildcard and the odd unreadable byte slipped in between.
    function automatic void plant_pattern(int n);
        logic [127:0] pat;
        region_byte_t b;

        pat = {pattern_hi, pattern_lo};
        for (int i = 0; i < n; i++)
        begin
            b.data     = wild_mask[i] ? wbps_pkg::byte_t'($urandom) : pat[8*i +: 8];
            b.readable = 1'b1;
            region_bytes.push_back(b);
            if ($urandom_range(0, 7) == 0)
            begin
                b.data     = wbps_pkg::byte_t'($urandom);
                b.readable = 1'b0;
                region_bytes.push_back(b);
            end
        end
    endfunction

    // One random configuration followed by a stream of regions. Most regions are
    // well formed, often with a partial pattern and a full one planted inside, so
    // that matches, suppressed repeats and misses all come up. The rest is noise
    // with random start and last flags.
    task automatic run_phase(int phase);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mask_word;
        logic [63:0] len_word;
        int          sent;
        int          len;
        int          count;

        lo        = {$urandom, $urandom};
        hi        = {$urandom, $urandom};
        mask_word = {$urandom, $urandom};
        len_word  = {$urandom, $urandom};

        case (phase)
            1: begin lo = '1; hi = '1; end
            2: begin lo = '0; hi = '0; end
            default: ;
        endcase

        case ($urandom_range(0, 3))
            0:       mask_word[15:0] = '0;
            1:       mask_word[15:0] = '1;
            default: mask_word[15:0] = 16'($urandom & $urandom);
        endcase

        // The first phases hold the length extremes, including the values that
        // are clamped to one and to the full window.
        case (phase)
            0:       len_word[4:0] = 5'd16;
            1:       len_word[4:0] = 5'd31;
            2:       len_word[4:0] = 5'd0;
            3:       len_word[4:0] = 5'd17;
            default: len_word[4:0] = ($urandom_range(0, 4) == 0) ?
                                     5'($urandom_range(9, 16)) : 5'($urandom_range(1, 8));
        endcase

        drain_stream();
        write_reg(wbps_pkg::CFG_PATTERN_LOW, lo);
        write_reg(wbps_pkg::CFG_PATTERN_HIGH, hi);
        write_reg(wbps_pkg::CFG_WILDCARD_MASK, mask_word);
        write_reg(wbps_pkg::CFG_PATTERN_LENGTH, len_word);
        if ($urandom_range(0, 2) == 0)
            write_reg(wbps_pkg::CFG_INDEX_W'($urandom_range(4, 255)), {$urandom, $urandom});

        len  = used_length(pattern_len);
        sent = 0;
        while (sent < PHASE_BYTES)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                count = $urandom_range(1, 12);
                repeat (count)
                    push_byte(wbps_pkg::byte_t'($urandom), $urandom_range(0, 3) != 0,
                              $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
                              1'b0, '0);
                sent += count;
            end
            else
            begin
                region_bytes.delete();
                repeat ($urandom_range(0, 8)) region_bytes.push_back(filler_byte());
                if ($urandom_range(0, 2) == 0)
                    plant_pattern($urandom_range(1, len));
                if ($urandom_range(0, 4) != 0)
                    plant_pattern(len);
                repeat ($urandom_range(0, 6)) region_bytes.push_back(filler_byte());
                if (region_bytes.size() == 0)
                    region_bytes.push_back(filler_byte());

                foreach (region_bytes[k])
                    push_byte(region_bytes[k].data, region_bytes[k].readable, k == 0,
                              k == region_bytes.size() - 1, 1'b0, '0);
                sent += region_bytes.size();
            end
        end
    endtask

    // Result side. Every accepted result transfer is checked field by field against
    // the oldest owed result. The receiver stalls in stretches: always ready, ready
    // at random, or ready on one cycle in four.
    int           stall_mode  = 0;
    int           stall_left  = 0;
    int           stall_tick  = 0;
    scan_result_t owed;

    always @(posedge clk)
    begin
        if (m_tvalid === 1'b1 && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no result owed: tdata %h tuser %b",
                       m_tdata, m_tuser);
                mismatch_count++;
            end
            else
            begin
                owed = pending_results.pop_front();
                if (m_tuser[0] !== owed.found)
                begin
                    $error("found: expected %0d, got %0d", owed.found, m_tuser[0]);
                    mismatch_count++;
                end
                if (m_tdata !== owed.match_offset)
                begin
                    $error("match_offset: expected %0d, got %0d",
                           owed.match_offset, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser[1] !== owed.region_missed)
                begin
                    $error("region_missed: expected %0d, got %0d",
                           owed.region_missed, m_tuser[1]);
                    mismatch_count++;
                end
            end
        end

        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 80);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= (stall_tick % 4 == 0);
        endcase
    end

    // Directed part, then the random phases, then the final verdict.
    initial
    begin
        // Columns: kind, register, value, data, readable, start, last, and for
        // known rows found, match_offset, region_missed.
        directed_rows = '{
            // Straight after reset the pattern is one zero byte, and the stream
            // counts as one region although no start has been seen.
            '{ROW_KNOWN, '0, '0, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
            '{ROW_KNOWN, '0, '0, 8'h00, 1'b1, 1'b0, 1'b1, 1'b1, 32'd1, 1'b0},
            // A skipped byte that opens and closes a region: nothing matched.
            '{ROW_KNOWN, '0, '0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 32'd0, 1'b1},
            // No new start after the last byte, so the same region goes on.
            '{ROW_KNOWN, '0, '0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1, 32'd1, 1'b0},
            '{ROW_KNOWN, '0, '0, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 32'd0, 1'b0},
            // Pattern 11 ?? 33, and a write to an index the block does not decode.
            '{ROW_WRITE, wbps_pkg::CFG_PATTERN_LOW, 64'h332211,
              '0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
            '{ROW_WRITE, wbps_pkg::CFG_WILDCARD_MASK, 64'h2,
              '0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
            '{ROW_WRITE, wbps_pkg::CFG_PATTERN_LENGTH, 64'd3,
              '0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
            '{ROW_WRITE, CFG_SPARE_INDEX, '1,
              '0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
            // A skipped byte inside the match still takes up an offset.
            '{ROW_BYTE,  '0, '0, 8'h11, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0},
            '{ROW_BYTE,  '0, '0, 8'h5A, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
            '{ROW_BYTE,  '0, '0, 8'h99, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
            '{ROW_KNOWN, '0, '0, 8'h33, 1'b1, 1'b0, 1'b0, 1'b1, 32'd0, 1'b0},
            // A second match in the same region is suppressed.
            '{ROW_BYTE,  '0, '0, 8'h11, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
            '{ROW_BYTE,  '0, '0, 8'h22, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
            '{ROW_KNOWN, '0, '0, 8'h33, 1'b1, 1'b0, 1'b1, 1'b0, 32'd0, 1'b0},
            // A partial match that fails must not hide the match one byte later.
            '{ROW_BYTE,  '0, '0, 8'h11, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0},
            '{ROW_BYTE,  '0, '0, 8'h11, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
            '{ROW_BYTE,  '0, '0, 8'h22, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
            '{ROW_KNOWN, '0, '0, 8'h33, 1'b1, 1'b0, 1'b1, 1'b1, 32'd1, 1'b0},
            // The closing byte of the pattern arrives unreadable: a miss.
            '{ROW_BYTE,  '0, '0, 8'h11, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0},
            '{ROW_BYTE,  '0, '0, 8'h22, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
            '{ROW_KNOWN, '0, '0, 8'h33, 1'b0, 1'b0, 1'b1, 1'b0, 32'd0, 1'b1},
            // All-ones pattern word and a length of zero, which acts as one.
            '{ROW_WRITE, wbps_pkg::CFG_PATTERN_LOW, '1,
              '0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
            '{ROW_WRITE, wbps_pkg::CFG_PATTERN_LENGTH, 64'd0,
              '0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
            '{ROW_WRITE, wbps_pkg::CFG_WILDCARD_MASK, 64'd0,
              '0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
            '{ROW_KNOWN, '0, '0, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 32'd0, 1'b0},
            '{ROW_KNOWN, '0, '0, 8'hFE, 1'b1, 1'b1, 1'b1, 1'b0, 32'd0, 1'b1}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[n])
        begin
            if (directed_rows[n].kind == ROW_WRITE)
            begin
                drain_stream();
                write_reg(directed_rows[n].reg_index, directed_rows[n].reg_value);
            end
            else
            begin
                push_byte(directed_rows[n].data, directed_rows[n].readable,
                          directed_rows[n].start, directed_rows[n].last,
                          directed_rows[n].kind == ROW_KNOWN,
                          {directed_rows[n].found, directed_rows[n].match_offset,
                           directed_rows[n].region_missed});
            end
        end

        for (int phase = 0; phase < PHASE_COUNT; phase++)
            run_phase(phase);

        // Let the last results come back, then wait on for anything stray.
        drain_stream();
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("wildcard_byte_pattern_scan test passed");
        else
            $display("wildcard_byte_pattern_scan test failed");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #200_000;
        $display("wildcard_byte_pattern_scan test failed");
        $finish;
    end

endmodule

/* files.f */
design/wbps_pkg.sv
design/wbps_cell.sv
design/wildcard_byte_pattern_scan.sv
design/wbps_checker.sv
bench/wildcard_byte_pattern_scan_test.sv
